[src/sec_pkg.sv]
`timescale 1ns / 1ps
package sec_pkg;
	localparam int StabWin = 16;
	localparam int AvgWin = 8;
	localparam int SW = 10;
	localparam int SwAw = $clog2(StabWin);
	localparam int AvAw = $clog2(AvgWin);
	localparam int Axes = 3;
	localparam int Trackers = 12;
	localparam int SumW = SW + AvAw;
	localparam logic [SW-1:0] MaxSample = 10'd1023;
	localparam logic [10:0] ThreshReset = 11'd8;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SWRITE, ST_SSCAN, ST_SDONE, ST_TSEL, ST_TWRITE, ST_TSUM, ST_TFIN, ST_OUT
	} state_t;
endpackage

[src/sec_ram.sv]
`timescale 1ns / 1ps
module sec_ram #(
	parameter int Width = 10,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/stable_extreme_calibrator_top.sv]
`timescale 1ns / 1ps
// One sample transaction of three 10-bit axes produces one result transaction with twelve
// tracker averages. Samples are handled one at a time by a sequencer around two memories,
// each with one write port and one registered read port: a 48-entry store of stability
// windows and a 96-entry store of averaging windows. An item is first accepted. The axes are
// then taken in turn until one is found unsettled: each writes its sample to its stability
// window, and an axis whose 16-entry window has filled is scanned for its spread. Each of the
// twelve trackers is then visited; a tracker that takes the sample writes it to its averaging
// window, and a window that fills is summed into a new average. The item then finishes and
// loads the output register. The input is accepted again as soon as the result sits in the
// output register, and a result that is still waiting there holds back the next one.
module stable_extreme_calibrator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [9:0]  sample_x,
	input  logic [9:0]  sample_y,
	input  logic [9:0]  sample_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  stable_min_x,
	output logic [9:0]  stable_max_x,
	output logic [9:0]  stable_min_y,
	output logic [9:0]  stable_max_y,
	output logic [9:0]  stable_min_z,
	output logic [9:0]  stable_max_z,
	output logic [9:0]  extreme_min_x,
	output logic [9:0]  extreme_max_x,
	output logic [9:0]  extreme_min_y,
	output logic [9:0]  extreme_max_y,
	output logic [9:0]  extreme_min_z,
	output logic [9:0]  extreme_max_z
);
	localparam int SW = sec_pkg::SW;
	localparam int SAddrW = $clog2(sec_pkg::Axes * sec_pkg::StabWin);
	localparam int TAddrW = $clog2(sec_pkg::Trackers * sec_pkg::AvgWin);

	sec_pkg::state_t state_q, state_d;
	logic [10:0] thresh_q;
	logic [SW-1:0] samp_q [sec_pkg::Axes];
	logic [1:0] axis_q;
	logic [sec_pkg::SwAw-1:0] spos_q [sec_pkg::Axes];
	logic [sec_pkg::Axes-1:0] armed_q;
	logic [sec_pkg::SwAw:0] scnt_q;
	logic [SW:0] lo_q, hi_q;
	logic all_stable_q;
	logic [3:0] trk_q;
	logic [sec_pkg::AvAw-1:0] tpos_q [sec_pkg::Trackers];
	logic [SW-1:0] avg_q [sec_pkg::Trackers];
	logic [SW-1:0] res_q [sec_pkg::Trackers];
	logic [sec_pkg::AvAw:0] tcnt_q;
	logic [sec_pkg::SumW-1:0] sum_q;
	logic out_valid_q;

	// Sample and average currently involved.
	logic [1:0] t_axis;
	logic [SW-1:0] t_v, t_avg_eff;
	logic t_hit, t_is_max;
	always_comb begin
		t_axis = (trk_q < 4'd6) ? trk_q[2:1] : 2'((trk_q - 4'd6) >> 1);
		t_v = samp_q[t_axis];
		t_is_max = trk_q[0];
		t_avg_eff = avg_q[trk_q];
		if (!t_is_max && t_avg_eff == '0) begin
			t_avg_eff = sec_pkg::MaxSample;
		end
		t_hit = t_is_max ? (t_avg_eff < t_v) : (t_avg_eff > t_v);
	end

	// Memories.
	logic s_we, t_we;
	logic [SAddrW-1:0] s_waddr, s_raddr;
	logic [TAddrW-1:0] t_waddr, t_raddr;
	logic [SW-1:0] s_rdata, t_rdata;

	assign s_we = (state_q == sec_pkg::ST_SWRITE);
	assign s_waddr = SAddrW'(axis_q) * SAddrW'(sec_pkg::StabWin) + SAddrW'(spos_q[axis_q]);
	assign s_raddr = SAddrW'(axis_q) * SAddrW'(sec_pkg::StabWin)
		+ SAddrW'(scnt_q[sec_pkg::SwAw-1:0]);
	assign t_we = (state_q == sec_pkg::ST_TWRITE);
	assign t_waddr = TAddrW'(trk_q) * TAddrW'(sec_pkg::AvgWin) + TAddrW'(tpos_q[trk_q]);
	assign t_raddr = TAddrW'(trk_q) * TAddrW'(sec_pkg::AvgWin)
		+ TAddrW'(tcnt_q[sec_pkg::AvAw-1:0]);

	sec_ram #(.Width(SW), .Depth(sec_pkg::Axes * sec_pkg::StabWin)) u_sram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(samp_q[axis_q]),
		.raddr(s_raddr), .rdata(s_rdata)
	);
	sec_ram #(.Width(SW), .Depth(sec_pkg::Trackers * sec_pkg::AvgWin)) u_tram (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_v),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	logic stab_ok;
	assign stab_ok = (hi_q - lo_q) < {1'b0, thresh_q};
	logic spos_wrap;
	assign spos_wrap = (spos_q[axis_q] == sec_pkg::SwAw'(sec_pkg::StabWin - 1));
	logic tpos_wrap;
	assign tpos_wrap = (tpos_q[trk_q] == sec_pkg::AvAw'(sec_pkg::AvgWin - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			sec_pkg::ST_IDLE: if (in_valid) state_d = sec_pkg::ST_SWRITE;
			sec_pkg::ST_SWRITE: begin
				if (armed_q[axis_q] || spos_wrap) state_d = sec_pkg::ST_SSCAN;
				else state_d = sec_pkg::ST_TSEL;
			end
			// Read counter runs one ahead because the memory read is registered.
			sec_pkg::ST_SSCAN: begin
				if (scnt_q == (sec_pkg::SwAw+1)'(sec_pkg::StabWin)) state_d = sec_pkg::ST_SDONE;
			end
			sec_pkg::ST_SDONE: begin
				if (stab_ok && axis_q != 2'd2) state_d = sec_pkg::ST_SWRITE;
				else state_d = sec_pkg::ST_TSEL;
			end
			sec_pkg::ST_TSEL: begin
				if (trk_q == 4'(sec_pkg::Trackers)) state_d = sec_pkg::ST_OUT;
				else if (trk_q < 4'd6 && !all_stable_q) state_d = sec_pkg::ST_TSEL;
				else if (t_hit) state_d = sec_pkg::ST_TWRITE;
			end
			sec_pkg::ST_TWRITE: begin
				if (tpos_wrap) state_d = sec_pkg::ST_TSUM;
				else state_d = sec_pkg::ST_TFIN;
			end
			sec_pkg::ST_TSUM: begin
				if (tcnt_q == (sec_pkg::AvAw+1)'(sec_pkg::AvgWin)) state_d = sec_pkg::ST_TFIN;
			end
			sec_pkg::ST_TFIN: state_d = sec_pkg::ST_TSEL;
			sec_pkg::ST_OUT: if (!out_valid_q || out_ready) state_d = sec_pkg::ST_IDLE;
			default: state_d = sec_pkg::ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == sec_pkg::ST_IDLE);
	assign cfg_ready = (state_q == sec_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sec_pkg::ST_IDLE;
			thresh_q <= sec_pkg::ThreshReset;
			armed_q <= '0;
			out_valid_q <= 1'b0;
			axis_q <= '0;
			trk_q <= '0;
			scnt_q <= '0;
			tcnt_q <= '0;
			all_stable_q <= 1'b0;
			for (int i = 0; i < sec_pkg::Axes; i++) spos_q[i] <= '0;
			for (int i = 0; i < sec_pkg::Trackers; i++) begin
				tpos_q[i] <= '0;
				avg_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == sec_pkg::ST_OUT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				sec_pkg::ST_IDLE: begin
					if (cfg_valid) thresh_q <= cfg_data;
					if (in_valid) begin
						samp_q[0] <= sample_x;
						samp_q[1] <= sample_y;
						samp_q[2] <= sample_z;
						axis_q <= '0;
						all_stable_q <= 1'b0;
						trk_q <= '0;
					end
				end
				sec_pkg::ST_SWRITE: begin
					spos_q[axis_q] <= spos_wrap ? '0 : spos_q[axis_q] + 1'b1;
					if (spos_wrap) armed_q[axis_q] <= 1'b1;
					scnt_q <= '0;
					lo_q <= 11'd1024;
					hi_q <= '0;
				end
				sec_pkg::ST_SSCAN: begin
					scnt_q <= scnt_q + 1'b1;
					if (scnt_q != '0) begin
						if ({1'b0, s_rdata} < lo_q) lo_q <= {1'b0, s_rdata};
						if ({1'b0, s_rdata} > hi_q) hi_q <= {1'b0, s_rdata};
					end
				end
				sec_pkg::ST_SDONE: begin
					if (stab_ok && axis_q == 2'd2) all_stable_q <= 1'b1;
					axis_q <= axis_q + 2'd1;
				end
				sec_pkg::ST_TSEL: begin
					if (trk_q != 4'(sec_pkg::Trackers)) begin
						if (trk_q < 4'd6 && !all_stable_q) begin
							trk_q <= trk_q + 4'd1;
						end else begin
							avg_q[trk_q] <= t_avg_eff;
							if (!t_hit) trk_q <= trk_q + 4'd1;
						end
					end
				end
				sec_pkg::ST_TWRITE: begin
					tpos_q[trk_q] <= tpos_wrap ? '0 : tpos_q[trk_q] + 1'b1;
					tcnt_q <= '0;
					sum_q <= '0;
				end
				sec_pkg::ST_TSUM: begin
					tcnt_q <= tcnt_q + 1'b1;
					if (tcnt_q != '0) sum_q <= sum_q + sec_pkg::SumW'(t_rdata);
					if (tcnt_q == (sec_pkg::AvAw+1)'(sec_pkg::AvgWin))
						avg_q[trk_q] <= SW'((sum_q + sec_pkg::SumW'(t_rdata)) >> sec_pkg::AvAw);
				end
				sec_pkg::ST_TFIN: trk_q <= trk_q + 4'd1;
				sec_pkg::ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						for (int i = 0; i < sec_pkg::Trackers; i++) res_q[i] <= avg_q[i];
					end
				end
				default: ;
			endcase
		end
	end

	assign stable_min_x = res_q[0];
	assign stable_max_x = res_q[1];
	assign stable_min_y = res_q[2];
	assign stable_max_y = res_q[3];
	assign stable_min_z = res_q[4];
	assign stable_max_z = res_q[5];
	assign extreme_min_x = res_q[6];
	assign extreme_max_x = res_q[7];
	assign extreme_min_y = res_q[8];
	assign extreme_max_y = res_q[9];
	assign extreme_min_z = res_q[10];
	assign extreme_max_z = res_q[11];
endmodule

[bench/stable_extreme_calibrator_top_tb.sv]
`timescale 1ns / 1ps
module stable_extreme_calibrator_top_tb;
	typedef struct packed {
		logic [sec_pkg::SW-1:0] x;
		logic [sec_pkg::SW-1:0] y;
		logic [sec_pkg::SW-1:0] z;
	} sample_t;

	typedef logic [sec_pkg::Trackers*sec_pkg::SW-1:0] averages_t;

	localparam int WatchdogLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [10:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [sec_pkg::SW-1:0] sample_x = '0;
	logic [sec_pkg::SW-1:0] sample_y = '0;
	logic [sec_pkg::SW-1:0] sample_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [sec_pkg::SW-1:0] res [sec_pkg::Trackers];

	stable_extreme_calibrator_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.stable_min_x(res[0]), .stable_max_x(res[1]),
		.stable_min_y(res[2]), .stable_max_y(res[3]),
		.stable_min_z(res[4]), .stable_max_z(res[5]),
		.extreme_min_x(res[6]), .extreme_max_x(res[7]),
		.extreme_min_y(res[8]), .extreme_max_y(res[9]),
		.extreme_min_z(res[10]), .extreme_max_z(res[11])
	);

	always #10 clk = ~clk;

	// Predictor state.
	logic [10:0] threshold;
	logic [sec_pkg::SW-1:0] stab_win [sec_pkg::Axes][sec_pkg::StabWin];
	int stab_pos [sec_pkg::Axes];
	bit stab_armed [sec_pkg::Axes];
	logic [sec_pkg::SW-1:0] avg_win [sec_pkg::Trackers][sec_pkg::AvgWin];
	int avg_pos [sec_pkg::Trackers];
	logic [sec_pkg::SW-1:0] averages [sec_pkg::Trackers];

	sample_t pending_samples[$];
	averages_t expected_averages[$];
	int sender_idle_pct = 27;
	int receiver_idle_pct = 59;
	bit sender_hold = 1'b0;
	int mismatches = 0;
	int idle_cycles = 0;
	bit stim_done = 1'b0;

	function automatic bit axis_settles(int a, logic [sec_pkg::SW-1:0] v);
		int lo, hi;
		lo = 1024;
		hi = 0;
		stab_win[a][stab_pos[a]] = v;
		stab_pos[a]++;
		if (stab_pos[a] >= sec_pkg::StabWin) begin
			stab_pos[a] = 0;
			stab_armed[a] = 1'b1;
		end
		if (!stab_armed[a])
			return 1'b0;
		for (int i = 0; i < sec_pkg::StabWin; i++) begin
			if (stab_win[a][i] < lo) lo = stab_win[a][i];
			if (stab_win[a][i] > hi) hi = stab_win[a][i];
		end
		return (hi - lo) < int'(threshold);
	endfunction

	function automatic void gather(int t, logic [sec_pkg::SW-1:0] v);
		int sum;
		sum = 0;
		avg_win[t][avg_pos[t]] = v;
		avg_pos[t]++;
		if (avg_pos[t] >= sec_pkg::AvgWin) begin
			avg_pos[t] = 0;
			for (int i = 0; i < sec_pkg::AvgWin; i++)
				sum += avg_win[t][i];
			averages[t] = sec_pkg::SW'(sum / sec_pkg::AvgWin);
		end
	endfunction

	function automatic void update_pair(int t, logic [sec_pkg::SW-1:0] v);
		if (averages[t] == 0)
			averages[t] = sec_pkg::MaxSample;
		if (averages[t] > v)
			gather(t, v);
		if (averages[t+1] < v)
			gather(t + 1, v);
	endfunction

	function automatic averages_t predict_averages(sample_t s);
		logic [sec_pkg::SW-1:0] v [sec_pkg::Axes];
		averages_t r;
		v[0] = s.x;
		v[1] = s.y;
		v[2] = s.z;
		// Later axes are skipped once one axis is unsettled.
		if (axis_settles(0, v[0]) && axis_settles(1, v[1]) && axis_settles(2, v[2])) begin
			for (int a = 0; a < sec_pkg::Axes; a++)
				update_pair(2 * a, v[a]);
		end
		for (int a = 0; a < sec_pkg::Axes; a++)
			update_pair(6 + 2 * a, v[a]);
		for (int t = 0; t < sec_pkg::Trackers; t++)
			r[t*sec_pkg::SW +: sec_pkg::SW] = averages[t];
		return r;
	endfunction

	// Driver.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_averages.push_back(predict_averages('{sample_x, sample_y, sample_z}));
		end
		if (!in_valid || in_ready) begin
			if (pending_samples.size() > 0 && !sender_hold &&
					$urandom_range(99) >= sender_idle_pct) begin
				sample_t s;
				s = pending_samples.pop_front();
				in_valid <= 1'b1;
				sample_x <= s.x;
				sample_y <= s.y;
				sample_z <= s.z;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// Monitor.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_averages.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction at %0t", $realtime);
			end else begin
				averages_t e;
				e = expected_averages.pop_front();
				for (int t = 0; t < sec_pkg::Trackers; t++) begin
					if (res[t] !== e[t*sec_pkg::SW +: sec_pkg::SW]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("tracker %0d: expected %0d, got %0d", t,
								e[t*sec_pkg::SW +: sec_pkg::SW], res[t]);
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("stable_extreme_calibrator_top_tb: FAIL");
			$finish;
		end
	end

	task automatic drain();
		while (pending_samples.size() > 0 || in_valid || expected_averages.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_threshold(logic [10:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		threshold = value;
	endtask

	task automatic queue_sample(int x, int y, int z);
		pending_samples.push_back('{sec_pkg::SW'(x), sec_pkg::SW'(y), sec_pkg::SW'(z)});
	endtask

	// A run of steady samples around a center, with small noise.
	task automatic queue_steady_run(int len, int spread);
		int c [sec_pkg::Axes];
		for (int a = 0; a < sec_pkg::Axes; a++)
			c[a] = $urandom_range(1023);
		for (int i = 0; i < len; i++) begin
			int v [sec_pkg::Axes];
			for (int a = 0; a < sec_pkg::Axes; a++) begin
				v[a] = c[a] + int'($urandom_range(spread)) - spread / 2;
				if (v[a] < 0) v[a] = 0;
				if (v[a] > 1023) v[a] = 1023;
			end
			queue_sample(v[0], v[1], v[2]);
		end
	endtask

	task automatic queue_random(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) < 7)
				queue_steady_run(20, $urandom_range(12));
			else
				queue_sample($urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
		end
	endtask

	initial begin
		threshold = sec_pkg::ThreshReset;
		for (int a = 0; a < sec_pkg::Axes; a++) begin
			stab_pos[a] = 0;
			stab_armed[a] = 1'b0;
		end
		for (int t = 0; t < sec_pkg::Trackers; t++) begin
			avg_pos[t] = 0;
			averages[t] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: extremes, zeros and a long steady run at reset threshold.
		queue_sample(0, 0, 0);
		queue_sample(1023, 1023, 1023);
		queue_sample(0, 1023, 0);
		queue_sample(1023, 0, 1023);
		for (int i = 0; i < 20; i++)
			queue_sample(512, 300 + (i % 2), 700);
		drain();

		write_threshold(11'd1024);
		queue_random(13);
		drain();
		write_threshold(11'd0);
		queue_random(3);
		drain();
		write_threshold(11'd1);
		queue_random(3);
		drain();
		write_threshold(11'd2047);
		queue_random(2);
		drain();
		write_threshold(11'd6);

		// The sender holds off until every expected result has arrived.
		sender_hold = 1'b1;
		queue_random(4);
		@(posedge clk);
		while (expected_averages.size() > 0 || in_valid) @(posedge clk);
		sender_hold = 1'b0;
		queue_random(3);
		drain();

		sender_idle_pct = 59;
		receiver_idle_pct = 27;
		write_threshold(11'd10);
		queue_random(3);
		drain();

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		write_threshold(11'd4);
		queue_random(3);
		drain();

		if (mismatches == 0)
			$display("stable_extreme_calibrator_top_tb: PASS");
		else
			$display("stable_extreme_calibrator_top_tb: FAIL");
		$finish;
	end
endmodule
